// ----- src/ps2a_pkg.sv -----
// Shared types, constants and key tables for the set 2 scan code decoder.
package ps2a_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int RUN_W       = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CODE_EXT    = 8'hE0;
  localparam logic [7:0] CODE_BREAK  = 8'hF0;
  localparam logic [7:0] CODE_PRTSC  = 8'h7C;
  localparam logic [7:0] CODE_CAPS   = 8'h58;
  localparam logic [7:0] CODE_LSHIFT = 8'h12;
  localparam logic [7:0] CODE_RSHIFT = 8'h59;
  localparam logic [7:0] CODE_BKSP   = 8'h66;
  localparam logic [7:0] CODE_TAB    = 8'h0D;

  localparam logic [6:0] CHAR_NONE   = 7'h00;
  localparam logic [6:0] CHAR_SPACE  = 7'h20;
  localparam logic [6:0] CHAR_LOW_A  = 7'h61;
  localparam logic [6:0] CHAR_LOW_Z  = 7'h7A;
  localparam logic [6:0] CASE_OFFSET = 7'h20;

  localparam logic [1:0] PRTSC_TAIL  = 2'd3;

  typedef enum logic [3:0] {
    PFX_IDLE = 4'b0001,
    PFX_E0   = 4'b0010,
    PFX_F0   = 4'b0100,
    PFX_E0F0 = 4'b1000
  } prefix_t;

  // One queued job: first character and how many more copies follow it.
  typedef struct packed {
    logic [6:0]       char_code;
    logic [RUN_W-1:0] rem;
  } job_t;

  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'h1C: ch = 7'h61;  7'h32: ch = 7'h62;  7'h21: ch = 7'h63;  7'h23: ch = 7'h64;
      7'h24: ch = 7'h65;  7'h2B: ch = 7'h66;  7'h34: ch = 7'h67;  7'h33: ch = 7'h68;
      7'h43: ch = 7'h69;  7'h3B: ch = 7'h6A;  7'h42: ch = 7'h6B;  7'h4B: ch = 7'h6C;
      7'h3A: ch = 7'h6D;  7'h31: ch = 7'h6E;  7'h44: ch = 7'h6F;  7'h4D: ch = 7'h70;
      7'h15: ch = 7'h71;  7'h2D: ch = 7'h72;  7'h1B: ch = 7'h73;  7'h2C: ch = 7'h74;
      7'h3C: ch = 7'h75;  7'h2A: ch = 7'h76;  7'h1D: ch = 7'h77;  7'h22: ch = 7'h78;
      7'h35: ch = 7'h79;  7'h1A: ch = 7'h7A;
      7'h16: ch = 7'h31;  7'h1E: ch = 7'h32;  7'h26: ch = 7'h33;  7'h25: ch = 7'h34;
      7'h2E: ch = 7'h35;  7'h36: ch = 7'h36;  7'h3D: ch = 7'h37;  7'h3E: ch = 7'h38;
      7'h46: ch = 7'h39;  7'h45: ch = 7'h30;
      7'h4E: ch = 7'h2D;  7'h55: ch = 7'h3D;  7'h0E: ch = 7'h60;  7'h54: ch = 7'h5B;
      7'h5B: ch = 7'h5D;  7'h4C: ch = 7'h3B;  7'h52: ch = 7'h27;  7'h5D: ch = 7'h5C;
      7'h41: ch = 7'h2C;  7'h49: ch = 7'h2E;  7'h4A: ch = 7'h2F;  7'h29: ch = 7'h20;
      7'h66: ch = 7'h08;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shift_char(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'h16: ch = 7'h21;  7'h1E: ch = 7'h40;  7'h26: ch = 7'h23;  7'h25: ch = 7'h24;
      7'h2E: ch = 7'h25;  7'h36: ch = 7'h5E;  7'h3D: ch = 7'h26;  7'h3E: ch = 7'h2A;
      7'h46: ch = 7'h28;  7'h45: ch = 7'h29;
      7'h4E: ch = 7'h5F;  7'h55: ch = 7'h2B;  7'h0E: ch = 7'h7E;  7'h54: ch = 7'h7B;
      7'h5B: ch = 7'h7D;  7'h4C: ch = 7'h3A;  7'h52: ch = 7'h27;  7'h5D: ch = 7'h7C;
      7'h41: ch = 7'h3C;  7'h49: ch = 7'h3E;  7'h4A: ch = 7'h3F;  7'h29: ch = 7'h20;
      7'h66: ch = 7'h08;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ----- src/ps2a_in_if.sv -----
// Input channel: one raw keyboard byte per word.
interface ps2a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

// ----- src/ps2a_out_if.sv -----
// Result channel: one ASCII character per word.
interface ps2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_of_run;

  modport source (output valid, output char_code, output last_of_run, input ready);
  modport sink   (input valid, input char_code, input last_of_run, output ready);
endinterface

// ----- src/ps2a_front.sv -----
// Front end: accept bytes, track prefixes and modifiers, classify into jobs.
module ps2a_front
  import ps2a_pkg::*;
#(
  parameter int TAB_SPACES = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  ps2a_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           push,
  output job_t           push_job
);

  localparam int TAB_N = (TAB_SPACES > MAX_RESULTS) ? MAX_RESULTS : TAB_SPACES;

  prefix_t    pfx_r, pfx_nxt;
  logic [1:0] skip_r, skip_nxt;
  logic       shift_r, shift_nxt;
  logic       caps_r, caps_nxt;
  logic       upper_r, upper_nxt;

  logic       take;
  logic [7:0] b;
  logic [6:0] pch;
  logic [6:0] sch;
  logic       is_letter;
  logic       is_shift_key;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.scan_byte;
  assign pch         = plain_char(b[6:0]);
  assign sch         = shift_char(b[6:0]);
  assign is_letter   = (pch >= CHAR_LOW_A) && (pch <= CHAR_LOW_Z);
  assign is_shift_key = (b == CODE_LSHIFT) || (b == CODE_RSHIFT);

  always_comb begin
    pfx_nxt   = pfx_r;
    skip_nxt  = skip_r;
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    upper_nxt = upper_r;
    push      = 1'b0;
    push_job  = '{char_code: CHAR_NONE, rem: '0};
    if (take) begin
      if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
      end else begin
        case (pfx_r)
          PFX_E0: begin
            pfx_nxt = (b == CODE_BREAK) ? PFX_E0F0 : PFX_IDLE;
          end
          PFX_E0F0: begin
            skip_nxt = (b == CODE_PRTSC) ? PRTSC_TAIL : 2'd0;
            pfx_nxt  = PFX_IDLE;
          end
          PFX_F0: begin
            if (is_shift_key) begin
              shift_nxt = 1'b0;
              upper_nxt = caps_r;
            end
            pfx_nxt = PFX_IDLE;
          end
          PFX_IDLE: begin
            if (b == CODE_EXT) begin
              pfx_nxt = PFX_E0;
            end else if (b == CODE_BREAK) begin
              pfx_nxt = PFX_F0;
            end else if (b == CODE_CAPS) begin
              caps_nxt  = !caps_r;
              upper_nxt = !caps_r ^ shift_r;
            end else if (is_shift_key) begin
              shift_nxt = 1'b1;
              upper_nxt = !caps_r;
            end else if (b == CODE_TAB) begin
              push     = 1'b1;
              push_job = '{char_code: CHAR_SPACE, rem: RUN_W'(TAB_N - 1)};
            end else if (!b[7] && (pch != CHAR_NONE)) begin
              push = 1'b1;
              if (is_letter) begin
                push_job.char_code = upper_r ? (pch - CASE_OFFSET) : pch;
              end else begin
                push_job.char_code = shift_r ? sch : pch;
              end
            end
          end
          default: pfx_nxt = PFX_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_r   <= PFX_IDLE;
      skip_r  <= 2'd0;
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
      upper_r <= 1'b0;
    end else begin
      pfx_r   <= pfx_nxt;
      skip_r  <= skip_nxt;
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
      upper_r <= upper_nxt;
    end
  end

endmodule

// ----- src/ps2a_queue.sv -----
// Short job queue between the front and back ends.
module ps2a_queue
  import ps2a_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t q_head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_head  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/ps2a_back.sv -----
// Back end: expand jobs into characters through the output register.
module ps2a_back
  import ps2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_head,
  output logic        pop,
  ps2a_out_if.source  out_ch
);

  logic             vld_r, vld_nxt;
  logic [6:0]       char_r, char_nxt;
  logic [RUN_W-1:0] rem_r, rem_nxt;
  logic             done;

  assign out_ch.valid       = vld_r;
  assign out_ch.char_code   = char_r;
  assign out_ch.last_of_run = (rem_r == '0);

  // Current run ends when its last character is taken.
  assign done = vld_r && out_ch.ready && (rem_r == '0);
  assign pop  = q_valid && (!vld_r || done);

  always_comb begin
    vld_nxt  = vld_r;
    char_nxt = char_r;
    rem_nxt  = rem_r;
    if (pop) begin
      vld_nxt  = 1'b1;
      char_nxt = q_head.char_code;
      rem_nxt  = q_head.rem;
    end else if (done) begin
      vld_nxt = 1'b0;
    end else if (vld_r && out_ch.ready) begin
      rem_nxt = rem_r - RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ----- src/ps2_set2_scancode_to_ascii.sv -----
// Top level of the set 2 scan code to ASCII decoder, US layout.
//
//  channel  direction  word                          handshake
//  in_ch    in         scan_byte[7:0]                valid/ready
//  out_ch   out        char_code[6:0], last_of_run   valid/ready
//
// One byte is accepted per cycle while the two-entry job queue has room.
// A byte yields at most one job; the back end sends one character per cycle while
// out_ch is ready, so a Tab gives a run of min(TAB_SPACES, 5) characters and other keys one.
// An accepted byte is registered into the job queue, then into the output register.
// Reset (rst_n low, synchronous) clears the prefix tracker, skip count,
// Shift, Caps Lock, the queue and the output valid flag.
// Output stalls back up through the queue; the input stalls only when it is full.
module ps2_set2_scancode_to_ascii
  import ps2a_pkg::*;
#(
  parameter int TAB_SPACES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  ps2a_in_if.sink     in_ch,
  ps2a_out_if.source  out_ch
);

  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  logic q_full;
  job_t q_head;

  // Classify bytes and keep modifier state; push printable keys as jobs.
  ps2a_front #(.TAB_SPACES(TAB_SPACES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple classification from character delivery.
  ps2a_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_head   (q_head)
  );

  // Expand each job into its run of characters.
  ps2a_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- src/ps2a_checker.sv -----
// Port-level checks for the decoder, bound to its top level.
module ps2a_checker
  import ps2a_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char_code,
  input logic       out_last_of_run
);

  // Hold a stalled word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code)
      && $stable(out_last_of_run))
    else $error("stalled output word changed");

  // Only a Tab run has more than one word, and it is all spaces.
  a_run_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_char_code == CHAR_SPACE)
    else $error("non-final word of a run is not a space");

  // Advance a run without a gap.
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid
      && out_char_code == CHAR_SPACE)
    else $error("run broken before its last word");

  // Drop nothing as a null character.
  a_no_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_code != CHAR_NONE)
    else $error("null character emitted");

endmodule

bind ps2_set2_scancode_to_ascii ps2a_checker u_ps2a_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_char_code   (out_ch.char_code),
  .out_last_of_run (out_ch.last_of_run)
);

// ----- verif/tb_top.sv -----
// Set 2 decoder bench: directed and random keystrokes checked against a local key model.
`timescale 1ns / 1ps

module tb_top;
  import ps2a_pkg::*;

  localparam int TAB_LEN     = 5;
  localparam int LONG_HOLD   = 100;   // receiver hold-off long enough to back the queue up
  localparam int WATCH_LIMIT = 1000;  // cycles without any handshake before giving up
  localparam int RANDOM_WORDS = 280;

  // US layout key positions, packed first-entry-in-the-top-byte.
  localparam logic [8*26-1:0] LETTER_SCANS = {
    8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B, 8'h42, 8'h4B, 8'h3A,
    8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C, 8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A};
  localparam logic [8*22-1:0] SYM_SCANS = {
    8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h45, 8'h4E,
    8'h55, 8'h0E, 8'h54, 8'h5B, 8'h4C, 8'h52, 8'h5D, 8'h41, 8'h49, 8'h4A, 8'h29};
  localparam logic [8*22-1:0] SYM_PLAIN = {
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h2D,
    8'h3D, 8'h60, 8'h5B, 8'h5D, 8'h3B, 8'h27, 8'h5C, 8'h2C, 8'h2E, 8'h2F, 8'h20};
  localparam logic [8*22-1:0] SYM_SHIFTED = {
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F,
    8'h2B, 8'h7E, 8'h7B, 8'h7D, 8'h3A, 8'h27, 8'h7C, 8'h3C, 8'h3E, 8'h3F, 8'h20};
  // Keys with no printable meaning: Enter, Esc, Ctrl, Alt, F1, Num Lock, keypad 1.
  localparam logic [8*7-1:0] DEAD_SCANS = {8'h5A, 8'h76, 8'h14, 8'h11, 8'h05, 8'h77, 8'h69};
  localparam logic [6:0] CHAR_BKSP = 7'h08;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_of_run;
  } ascii_word_t;

  typedef struct packed {
    logic [7:0] scan;
    logic       drain_first;  // hold this word back until every character has come out
  } feed_word_t;

  logic clk;
  logic rst_n;

  ps2a_in_if  in_ch ();
  ps2a_out_if out_ch ();

  ps2_set2_scancode_to_ascii #(
    .TAB_SPACES (TAB_LEN)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Key tables of the local keyboard model, filled at time zero.
  logic [6:0] plain_tbl   [0:255];
  logic [6:0] shifted_tbl [0:255];
  logic       letter_tbl  [0:255];

  // Keyboard state as the decoder should see it.
  prefix_t    kb_prefix;
  logic [1:0] kb_skip;
  logic       kb_shift;
  logic       kb_caps;
  logic       kb_upper;

  ascii_word_t char_expect_q [$];
  feed_word_t  scan_feed_q [$];

  int  errors;
  int  bytes_sent;
  int  chars_seen;
  int  send_gap;
  int  rcv_stall;
  int  hold_left;
  int  idle_cycles;
  int  drain_mark;
  logic drain_next;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length for one word; every 60 words a stretch of 15 goes back to back.
  function automatic int draw_gap(input int idx);
    return ((idx % 60) < 15) ? 0 : $urandom_range(0, 6);
  endfunction

  // Advance the keyboard model by one byte and queue the characters it yields.
  function automatic void predict_chars(input logic [7:0] b);
    logic [6:0] ch;
    int         n;
    if (kb_skip != 2'd0) begin
      // drop print-screen tail bytes, whatever they are
      kb_skip = kb_skip - 2'd1;
      return;
    end
    case (kb_prefix)
      PFX_E0: begin
        // extended make is swallowed; only F0 carries on to an extended break
        kb_prefix = (b == CODE_BREAK) ? PFX_E0F0 : PFX_IDLE;
        return;
      end
      PFX_E0F0: begin
        // extended break never releases Shift; print-screen break arms the skip
        kb_skip   = (b == CODE_PRTSC) ? PRTSC_TAIL : 2'd0;
        kb_prefix = PFX_IDLE;
        return;
      end
      PFX_F0: begin
        if (b == CODE_LSHIFT || b == CODE_RSHIFT) begin
          kb_shift = 1'b0;
          kb_upper = kb_caps;
        end
        kb_prefix = PFX_IDLE;
        return;
      end
      default: ;
    endcase
    if (b == CODE_EXT) begin
      kb_prefix = PFX_E0;
      return;
    end
    if (b == CODE_BREAK) begin
      kb_prefix = PFX_F0;
      return;
    end
    kb_prefix = PFX_IDLE;
    if (b == CODE_CAPS) begin
      kb_caps  = ~kb_caps;
      kb_upper = kb_caps ^ kb_shift;
      return;
    end
    if (b == CODE_LSHIFT || b == CODE_RSHIFT) begin
      kb_shift = 1'b1;
      kb_upper = ~kb_caps;
      return;
    end
    if (b == CODE_TAB) begin
      // a run of spaces, marked last on the final one
      n = (TAB_LEN > MAX_RESULTS) ? MAX_RESULTS : TAB_LEN;
      for (int k = 0; k < n; k++)
        char_expect_q.push_back('{CHAR_SPACE, k == n - 1});
      return;
    end
    if (letter_tbl[b]) begin
      // letter case follows Caps Lock XOR Shift
      ch = kb_upper ? plain_tbl[b] - CASE_OFFSET : plain_tbl[b];
      char_expect_q.push_back('{ch, 1'b1});
      return;
    end
    // digits and punctuation follow Shift alone; unmapped codes give nothing
    ch = kb_shift ? shifted_tbl[b] : plain_tbl[b];
    if (ch != CHAR_NONE)
      char_expect_q.push_back('{ch, 1'b1});
  endfunction

  task automatic push_byte(input logic [7:0] b);
    scan_feed_q.push_back('{b, drain_next});
    drain_next = 1'b0;
  endtask

  function automatic logic [7:0] pick_printable();
    int idx;
    idx = $urandom_range(0, 49);
    if (idx < 26) return LETTER_SCANS[8*(25-idx) +: 8];
    if (idx < 48) return SYM_SCANS[8*(47-idx) +: 8];
    return (idx == 48) ? CODE_TAB : CODE_BKSP;
  endfunction

  // Queue one keystroke-shaped sequence; a minority are noise or broken sequences.
  task automatic push_keystroke();
    int         kind;
    logic [7:0] code;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      code = pick_printable();
      push_byte(code);
      if ($urandom_range(0, 1) == 0) begin
        push_byte(CODE_BREAK);
        push_byte(code);
      end
    end else if (kind < 70) begin
      push_byte(($urandom_range(0, 1) == 0) ? CODE_LSHIFT : CODE_RSHIFT);
    end else if (kind < 78) begin
      push_byte(CODE_BREAK);
      push_byte(($urandom_range(0, 1) == 0) ? CODE_LSHIFT : CODE_RSHIFT);
    end else if (kind < 81) begin
      push_byte(CODE_CAPS);
      push_byte(CODE_BREAK);
      push_byte(CODE_CAPS);
    end else if (kind < 87) begin
      // extended make, sometimes followed by its break
      code = $urandom_range(0, 255);
      push_byte(CODE_EXT);
      push_byte(code);
      if ($urandom_range(0, 1) == 0) begin
        push_byte(CODE_EXT);
        push_byte(CODE_BREAK);
        push_byte(code);
      end
    end else if (kind < 90) begin
      // full print-screen press and release; the release tail is skipped
      push_byte(CODE_EXT);
      push_byte(CODE_LSHIFT);
      push_byte(CODE_EXT);
      push_byte(CODE_PRTSC);
      push_byte(CODE_EXT);
      push_byte(CODE_BREAK);
      push_byte(CODE_PRTSC);
      if ($urandom_range(0, 2) == 0) begin
        // broken tail: three random bytes instead
        repeat (3) push_byte($urandom_range(0, 255));
      end else begin
        push_byte(CODE_EXT);
        push_byte(CODE_BREAK);
        push_byte(CODE_LSHIFT);
      end
    end else if (kind < 94) begin
      push_byte(DEAD_SCANS[8*$urandom_range(0, 6) +: 8]);
    end else begin
      push_byte($urandom_range(0, 255));
    end
  endtask

  // Driver: offer the next queued word after its drawn gap, hold it until taken.
  always @(posedge clk) begin : scan_driver
    feed_word_t head;
    logic       offer;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.scan_byte <= '0;
      send_gap         = 0;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_chars(in_ch.scan_byte);
        bytes_sent++;
        offer    = 1'b0;
        send_gap = draw_gap(bytes_sent);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (scan_feed_q.size() != 0) begin
          head = scan_feed_q[0];
          if (!head.drain_first || char_expect_q.size() == 0) begin
            void'(scan_feed_q.pop_front());
            in_ch.scan_byte <= head.scan;
            offer = 1'b1;
          end
        end
      end
      in_ch.valid <= offer;
    end
  end

  // Monitor: check each taken character against the oldest expectation, then stall.
  always @(posedge clk) begin : char_monitor
    ascii_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rcv_stall     = 0;
      hold_left     = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        chars_seen++;
        if (char_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected character, expected none, got %02h last %0b",
                   $time, out_ch.char_code, out_ch.last_of_run);
        end else begin
          want = char_expect_q.pop_front();
          if (out_ch.char_code !== want.char_code) begin
            errors++;
            $display("%0t: char_code mismatch, expected %02h, got %02h",
                     $time, want.char_code, out_ch.char_code);
          end
          if (out_ch.last_of_run !== want.last_of_run) begin
            errors++;
            $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                     $time, want.last_of_run, out_ch.last_of_run);
          end
        end
        rcv_stall = draw_gap(chars_seen + 30);
        // twice in the run, hold off long enough for the input to back up
        if (chars_seen == 25 || chars_seen == 75)
          hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rcv_stall > 0) begin
        rcv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when no word moves on either side for too long.
  always @(posedge clk) begin : stall_watch
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] code;
    rst_n           = 1'b0;
    errors          = 0;
    bytes_sent      = 0;
    chars_seen      = 0;
    drain_next      = 1'b0;
    kb_prefix       = PFX_IDLE;
    kb_skip         = 2'd0;
    kb_shift        = 1'b0;
    kb_caps         = 1'b0;
    kb_upper        = 1'b0;

    // build the key tables
    for (int i = 0; i < 256; i++) begin
      plain_tbl[i]   = CHAR_NONE;
      shifted_tbl[i] = CHAR_NONE;
      letter_tbl[i]  = 1'b0;
    end
    for (int i = 0; i < 26; i++) begin
      code             = LETTER_SCANS[8*(25-i) +: 8];
      plain_tbl[code]  = CHAR_LOW_A + 7'(i);
      letter_tbl[code] = 1'b1;
    end
    for (int i = 0; i < 22; i++) begin
      code              = SYM_SCANS[8*(21-i) +: 8];
      plain_tbl[code]   = SYM_PLAIN[8*(21-i) +: 7];
      shifted_tbl[code] = SYM_SHIFTED[8*(21-i) +: 7];
    end
    plain_tbl[CODE_BKSP]   = CHAR_BKSP;
    shifted_tbl[CODE_BKSP] = CHAR_BKSP;

    // directed part
    push_byte(8'h00);                     // lowest byte, unmapped
    push_byte(8'hFF);                     // highest byte, above the table
    push_byte(8'h1C);                     // 'a'
    push_byte(8'h5D);                     // unshifted backslash
    push_byte(CODE_LSHIFT);
    push_byte(8'h2E);                     // shift+5 gives percent
    push_byte(8'h49);                     // shift+dot gives greater-than
    push_byte(8'h52);                     // apostrophe ignores shift
    push_byte(8'h1A);                     // 'Z'
    push_byte(CODE_EXT);                  // extended break of the shift code: no release
    push_byte(CODE_BREAK);
    push_byte(CODE_LSHIFT);
    push_byte(8'h4E);                     // still shifted: underscore
    push_byte(CODE_BREAK);                // right shift break releases shift
    push_byte(CODE_RSHIFT);
    push_byte(CODE_CAPS);                 // caps on
    push_byte(8'h1A);                     // 'Z' via caps
    push_byte(CODE_TAB);                  // run of spaces
    push_byte(CODE_EXT);                  // print-screen break, then a dropped tail
    push_byte(CODE_BREAK);
    push_byte(CODE_PRTSC);
    push_byte(CODE_TAB);
    push_byte(CODE_EXT);
    push_byte(CODE_BREAK);
    push_byte(CODE_EXT);                  // E0 prefix after the dropped tail
    push_byte(CODE_EXT);                  // second E0 swallowed as a make code; backspace then types
    push_byte(CODE_BKSP);

    // random keystrokes; every 110 words or so, wait for the output to drain first
    drain_mark = scan_feed_q.size();
    while (scan_feed_q.size() < drain_mark + RANDOM_WORDS) begin
      if (scan_feed_q.size() >= drain_mark + 110 * ((scan_feed_q.size() - drain_mark) / 110)
          && (scan_feed_q.size() - drain_mark) % 110 < 3)
        drain_next = 1'b1;
      push_keystroke();
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // hold until every word is taken and every character has come out
    while (scan_feed_q.size() != 0 || in_ch.valid || char_expect_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0 && char_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
